### design/renc_pkg.sv
package renc_pkg;

  localparam int unsigned FreqW   = 16;
  localparam int unsigned CumW    = 16;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned StateW  = 32;
  localparam int unsigned ProdW   = StateW + CfgW;
  localparam int unsigned NextW   = ProdW + 1;

  localparam logic [StateW-1:0] InitState  = 32'd123;
  localparam logic [StateW-1:0] StateMax   = 32'hFFFF_FFFF;
  localparam logic [CfgW-1:0]   MinBase    = 16'd256;
  localparam logic [CfgW-1:0]   TotalReset = 16'hFFFF;
  localparam logic [CfgW-1:0]   BaseReset  = 16'hFFFF;

  // input queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // shared restoring divider, one quotient bit per cycle
  localparam int unsigned DivSteps = StateW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL = 1'b0,
    CFG_BASE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [CumW-1:0]  cum;
    logic             fin;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [StateW-1:0] dividend;
    logic [FreqW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [StateW-1:0] quotient;
    logic [FreqW-1:0]  remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVF,
    ST_MUL,
    ST_CHK,
    ST_DIVB,
    ST_EMIT
  } back_state_e;

endpackage

### design/rans_encoder_step.sv
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_stall_o  symbol_frequency_i, symbol_cumulative_i,
//                                            final_symbol_i
// out      source     out_valid_o/out_stall_i code_word_o, last_word_o
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A symbol runs through the 32-step shared divider computing state/frequency,
// then the multiply and the range check.
// Each normalization word adds a divide by base, an emit and a divide again by
// frequency; each flush word adds a divide by base and an emit.
// Reset loads the coder state with 123 and both registers with 65535.
// A two-symbol queue lets the input side accept symbols while the back end works;
// a stalled output holds the back end in its emit step only.
module rans_encoder_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // symbol input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [renc_pkg::FreqW-1:0]   symbol_frequency_i,
  input  logic [renc_pkg::CumW-1:0]    symbol_cumulative_i,
  input  logic                         final_symbol_i,
  // code word output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [renc_pkg::WordW-1:0]   code_word_o,
  output logic                         last_word_o,
  // register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [renc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [renc_pkg::CfgW-1:0]    cfg_data_i
);
  import renc_pkg::*;

  logic [CfgW-1:0] total_q, total_d;
  logic [CfgW-1:0] base_q, base_d;
  logic [CfgW-1:0] base_eff;
  cfg_reg_e        cfg_reg;
  logic            item_valid;
  item_t           item;
  logic            item_pop;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  // Register writes are always taken; software must write only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  always_comb begin
    total_d = total_q;
    base_d  = base_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg)
        CFG_TOTAL: total_d = cfg_data_i;
        CFG_BASE:  base_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
      base_q  <= BaseReset;
    end else begin
      total_q <= total_d;
      base_q  <= base_d;
    end
  end

  // Clamp the word radix to at least 256 so the divide by base always shrinks
  // the state fast enough.
  assign base_eff = (base_q < MinBase) ? MinBase : base_q;

  // Front: accept, patch a zero frequency, queue.
  renc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .freq_i       (symbol_frequency_i),
    .cum_i        (symbol_cumulative_i),
    .fin_i        (final_symbol_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back: encode step, renormalization and flush sequencer.
  renc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .total_i      (total_q),
    .base_i       (base_eff),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_word_o  (code_word_o),
    .last_word_o  (last_word_o)
  );

  // Shared divider for both state/frequency and state/base.
  renc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

### design/renc_div.sv
module renc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  renc_pkg::div_req_t req_i,
  output renc_pkg::div_rsp_t rsp_o
);
  import renc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [StateW-1:0]  quo_q, quo_d;
  logic [FreqW-1:0]   rem_q, rem_d;
  logic [FreqW-1:0]   dvs_q, dvs_d;
  logic [FreqW:0]     trial;
  logic [FreqW:0]     diff;
  logic               ge;

  assign trial = {rem_q, quo_q[StateW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? diff[FreqW-1:0] : trial[FreqW-1:0];
      quo_d = {quo_q[StateW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### design/renc_front.sv
module renc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [renc_pkg::FreqW-1:0]        freq_i,
  input  logic [renc_pkg::CumW-1:0]         cum_i,
  input  logic                              fin_i,
  output logic                              item_valid_o,
  output renc_pkg::item_t                   item_o,
  input  logic                              item_pop_i
);
  import renc_pkg::*;

  item_t            queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;
  item_t            item_in;

  assign in_stall_o   = (cnt_q == QCntW'(QDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  // a zero frequency counts as one
  always_comb begin
    item_in.freq = (freq_i == '0) ? FreqW'(1) : freq_i;
    item_in.cum  = cum_i;
    item_in.fin  = fin_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### design/renc_back.sv
module renc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [renc_pkg::CfgW-1:0]  total_i,
  input  logic [renc_pkg::CfgW-1:0]  base_i,
  input  logic                       item_valid_i,
  input  renc_pkg::item_t            item_i,
  output logic                       item_pop_o,
  output renc_pkg::div_req_t         div_req_o,
  input  renc_pkg::div_rsp_t         div_rsp_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [renc_pkg::WordW-1:0] code_word_o,
  output logic                       last_word_o
);
  import renc_pkg::*;

  back_state_e       state_q, state_d;
  logic [StateW-1:0] s_q, s_d;
  logic [FreqW-1:0]  f_q, f_d;
  logic [CumW-1:0]   cum_q, cum_d;
  logic              fin_q, fin_d;
  logic              flush_q, flush_d;
  logic [StateW-1:0] quot_q, quot_d;
  logic [FreqW-1:0]  rem_q, rem_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [WordW-1:0]  word_q, word_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_word_q, out_word_d;
  logic              out_last_q, out_last_d;
  logic [NextW-1:0]  next_v;
  logic              over;
  logic              out_free;

  assign next_v   = NextW'(prod_q) + NextW'(rem_q) + NextW'(cum_q);
  assign over     = next_v > NextW'(StateMax);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_valid_i) state_d = ST_DIVF;
      ST_DIVF: if (div_rsp_i.done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_CHK;
      ST_CHK: begin
        if (over) begin
          state_d = ST_DIVB;
        end else if (fin_q) begin
          state_d = (next_v == '0) ? ST_EMIT : ST_DIVB;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVB: if (div_rsp_i.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (!flush_q) begin
            state_d = ST_DIVF;
          end else begin
            state_d = last_q ? ST_IDLE : ST_DIVB;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_d        = s_q;
    f_d        = f_q;
    cum_d      = cum_q;
    fin_d      = fin_q;
    flush_d    = flush_q;
    quot_d     = quot_q;
    rem_d      = rem_q;
    prod_d     = prod_q;
    word_d     = word_q;
    last_d     = last_q;
    out_word_d = out_word_q;
    out_last_d = out_last_q;
    item_pop_o = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = s_q;
    div_req_o.divisor  = f_q;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o         = 1'b1;
          f_d                = item_i.freq;
          cum_d              = item_i.cum;
          fin_d              = item_i.fin;
          flush_d            = 1'b0;
          div_req_o.start    = 1'b1;
          div_req_o.divisor  = item_i.freq;
        end
      end
      ST_DIVF: begin
        if (div_rsp_i.done) begin
          quot_d = div_rsp_i.quotient;
          rem_d  = div_rsp_i.remainder;
        end
      end
      ST_MUL: begin
        prod_d = ProdW'(total_i) * ProdW'(quot_q);
      end
      ST_CHK: begin
        if (over) begin
          div_req_o.start   = 1'b1;
          div_req_o.divisor = base_i;
        end else begin
          s_d = next_v[StateW-1:0];
          if (fin_q) begin
            flush_d = 1'b1;
            if (next_v == '0) begin
              // nothing left to flush: still mark the end of the message
              word_d = '0;
              last_d = 1'b1;
            end else begin
              div_req_o.start    = 1'b1;
              div_req_o.dividend = next_v[StateW-1:0];
              div_req_o.divisor  = base_i;
            end
          end
        end
      end
      ST_DIVB: begin
        if (div_rsp_i.done) begin
          s_d    = div_rsp_i.quotient;
          word_d = div_rsp_i.remainder;
          last_d = flush_q && (div_rsp_i.quotient == '0);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_word_d = word_q;
          out_last_d = last_q;
          if (!flush_q) begin
            div_req_o.start = 1'b1;
          end else if (last_q) begin
            s_d = InitState;
          end else begin
            div_req_o.start   = 1'b1;
            div_req_o.divisor = base_i;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_EMIT && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s_q         <= InitState;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    cum_q      <= cum_d;
    fin_q      <= fin_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    prod_q     <= prod_d;
    word_q     <= word_d;
    last_q     <= last_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_word_o = out_word_q;
  assign last_word_o = out_last_q;

endmodule

### tb/sv/tb_rans_encoder_step.sv
module tb_rans_encoder_step;
  import renc_pkg::*;

  // The idle tail covers the worst symbol, and two more that sit in the input queue.
  localparam int unsigned IdleTail = 1200;
  localparam int unsigned RunLimit = 600000;
  localparam int unsigned PhaseLen = 32;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } code_exp_t;

  // One row of the directed table: a register load or a symbol.
  typedef struct {
    bit               load;
    logic [CfgW-1:0]  total;
    logic [CfgW-1:0]  base;
    logic [FreqW-1:0] freq;
    logic [CumW-1:0]  cum;
    logic             fin;
    bit               typed;
    logic [WordW-1:0] typed_word;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [FreqW-1:0]    symbol_frequency_i = '0;
  logic [CumW-1:0]     symbol_cumulative_i = '0;
  logic                final_symbol_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WordW-1:0]    code_word_o;
  logic                last_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_TOTAL;
  logic [CfgW-1:0]     cfg_data_i = '0;

  // Shadow of the coder: state and both registers.
  longint unsigned     model_state = InitState;
  longint unsigned     model_total = TotalReset;
  longint unsigned     model_base = BaseReset;

  code_exp_t           pending_words[$];
  dir_row_t            directed_rows[$];
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         in_calm_left = 0;
  int unsigned         out_calm_left = 0;
  int unsigned         out_hold_left = 0;

  rans_encoder_step u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .symbol_frequency_i  (symbol_frequency_i),
    .symbol_cumulative_i (symbol_cumulative_i),
    .final_symbol_i      (final_symbol_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .code_word_o         (code_word_o),
    .last_word_o         (last_word_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // State the encode would reach from s: total*(s/f) + s%f + cum.
  function automatic longint unsigned grown_state(longint unsigned s, longint unsigned f,
                                                  longint unsigned c);
    return model_total * (s / f) + (s % f) + c;
  endfunction

  // Advance the shadow coder by one symbol; queue the words it emits when keep is set.
  function automatic void encode_symbol(logic [FreqW-1:0] freq, logic [CumW-1:0] cum,
                                        logic fin, bit keep);
    longint unsigned f;
    longint unsigned s;
    longint unsigned radix;
    longint unsigned w;
    f = (freq == '0) ? 1 : freq;
    s = model_state;
    radix = (model_base < MinBase) ? MinBase : model_base;
    // Renormalize: shift out low digits until the encode fits in 32 bits.
    while (grown_state(s, f, cum) > StateMax) begin
      w = s % radix;
      if (keep) pending_words.push_back({w[WordW-1:0], 1'b0});
      s = s / radix;
    end
    s = grown_state(s, f, cum);
    if (fin) begin
      // An empty state still gets one word so the end of message is marked.
      if (s == 0) begin
        if (keep) pending_words.push_back({{WordW{1'b0}}, 1'b1});
      end else begin
        while (s != 0) begin
          w = s % radix;
          s = s / radix;
          if (keep) pending_words.push_back({w[WordW-1:0], s == 0});
        end
      end
      s = InitState;
    end
    model_state = s & StateMax;
  endfunction

  function automatic dir_row_t load_row(logic [CfgW-1:0] total, logic [CfgW-1:0] base);
    dir_row_t r;
    r = '{load: 1'b1, total: total, base: base, freq: '0, cum: '0, fin: 1'b0,
          typed: 1'b0, typed_word: '0};
    return r;
  endfunction

  function automatic dir_row_t sym_row(logic [FreqW-1:0] freq, logic [CumW-1:0] cum,
                                       logic fin, bit typed, logic [WordW-1:0] word);
    dir_row_t r;
    r = '{load: 1'b0, total: '0, base: '0, freq: freq, cum: cum, fin: fin,
          typed: typed, typed_word: word};
    return r;
  endfunction

  // Present one symbol after a random gap and hold it until accepted.
  task automatic send_symbol(logic [FreqW-1:0] freq, logic [CumW-1:0] cum, logic fin,
                             bit typed, logic [WordW-1:0] word);
    int unsigned gap;
    if (in_calm_left > 0) begin
      in_calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) in_calm_left = 12;
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_frequency_i <= freq;
    symbol_cumulative_i <= cum;
    final_symbol_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    // A typed row carries its single closing word; the shadow still advances.
    if (typed) pending_words.push_back({word, 1'b1});
    encode_symbol(freq, cum, fin, !typed);
  endtask

  // Drop valid, wait out every expected word, then give the back end time to go quiet.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  // Write both registers back to back; valid stays high across the pair.
  task automatic load_registers(logic [CfgW-1:0] total, logic [CfgW-1:0] base);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TOTAL;
    cfg_data_i <= total;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_total = total;
    cfg_index_i <= CFG_BASE;
    cfg_data_i <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_base = base;
    cfg_valid_i <= 1'b0;
  endtask

  // Word sink: check every accepted word, then hold stall for a random count.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual code_word %h last_word %b",
                 $time, code_word_o, last_word_o);
        fail_count++;
      end else begin
        if (pending_words[0].word !== code_word_o) begin
          $display("%0t: code_word mismatch: expected %h actual %h",
                   $time, pending_words[0].word, code_word_o);
          fail_count++;
        end
        if (pending_words[0].last !== last_word_o) begin
          $display("%0t: last_word mismatch: expected %b actual %b",
                   $time, pending_words[0].last, last_word_o);
          fail_count++;
        end
        void'(pending_words.pop_front());
      end
      if (out_calm_left > 0) begin
        out_calm_left--;
        out_hold_left = 0;
      end else begin
        if ($urandom_range(0, 7) == 0) out_calm_left = 8;
        out_hold_left = $urandom_range(0, 9);
      end
      out_stall_i <= (out_hold_left != 0);
    end else if (rst_ni && out_valid_o && out_stall_i) begin
      if (out_hold_left > 0) out_hold_left--;
      out_stall_i <= (out_hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("rans_encoder_step verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t        r;
    longint unsigned gen_total;
    int unsigned     msg_left;
    logic [FreqW-1:0] f;
    logic [CumW-1:0]  c;
    logic             fin;

    // Reset values first: a lone symbol with f = total just flushes 123.
    directed_rows.push_back(sym_row(16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'd123));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b0, 1'b0, '0));
    // zero frequency counts as one
    directed_rows.push_back(sym_row(16'h0000, 16'hFFFE, 1'b1, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h8000, 16'h7FFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h7FFF, 16'h8000, 1'b1, 1'b0, '0));
    // total of one keeps the state; smallest legal base
    directed_rows.push_back(load_row(16'd1, 16'd256));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b1, 1'b1, 16'd123));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0));
    // zero total and zero base: the encode collapses to zero, an empty flush
    directed_rows.push_back(load_row(16'd0, 16'd0));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b1, 1'b1, 16'd0));
    directed_rows.push_back(sym_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0002, 16'h0001, 1'b1, 1'b0, '0));
    // base of one rounds up to 256; drive renormalization hard
    directed_rows.push_back(load_row(16'hFFFF, 16'd1));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0003, 16'h0007, 1'b1, 1'b0, '0));
    directed_rows.push_back(load_row(16'hFFFF, 16'd255));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b1, 1'b0, '0));
    directed_rows.push_back(load_row(16'hFFFF, 16'd256));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'hFFFF, 1'b1, 1'b0, '0));
    directed_rows.push_back(load_row(16'hFFFF, 16'hFFFF));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'h0001, 16'h0000, 1'b0, 1'b0, '0));
    directed_rows.push_back(sym_row(16'hFFFF, 16'hFFFE, 1'b1, 1'b0, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.load) begin
        settle_block();
        load_registers(r.total, r.base);
      end else begin
        send_symbol(r.freq, r.cum, r.fin, r.typed, r.typed_word);
      end
    end

    // Random phases: mostly well-formed messages, one symbol in eight is noise.
    for (int phase = 0; phase < 6; phase++) begin
      settle_block();
      case (phase)
        0: load_registers(16'hFFFF, 16'hFFFF);
        1: load_registers(CfgW'($urandom_range(2, 65534)), CfgW'($urandom_range(256, 65535)));
        2: load_registers(16'd1, 16'd256);
        3: load_registers(16'd0, CfgW'($urandom_range(0, 255)));
        4: load_registers(CfgW'($urandom_range(2, 300)), 16'hFFFF);
        default: load_registers(CfgW'($urandom_range(1000, 65535)),
                                CfgW'($urandom_range(256, 4096)));
      endcase
      gen_total = (model_total == 0) ? 1 : model_total;
      msg_left = 0;
      for (int n = 0; n < PhaseLen; n++) begin
        if (msg_left == 0) msg_left = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
          f = FreqW'($urandom_range(0, 65535));
          c = CumW'($urandom_range(0, 65535));
          fin = 1'($urandom_range(0, 1));
        end else begin
          f = FreqW'($urandom_range(1, 32'(gen_total)));
          c = CumW'($urandom_range(0, 32'(gen_total - f)));
          fin = (msg_left == 1);
        end
        msg_left--;
        send_symbol(f, c, fin, 1'b0, '0);
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("rans_encoder_step verification clean");
    end else begin
      $display("rans_encoder_step verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/renc_pkg.sv
design/renc_div.sv
design/renc_front.sv
design/renc_back.sv
design/rans_encoder_step.sv
tb/sv/tb_rans_encoder_step.sv
